/* hw/rtl/pmd_pkg.sv */
`timescale 1ns / 1ps

package pmd_pkg;

    localparam int unsigned SUM_W  = 16;
    localparam int unsigned WIDE_W = 22;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [7:0] HDR_MASK  = 8'hC8;
    localparam logic [7:0] HDR_VALUE = 8'h08;
    localparam int unsigned X_SIGN_BIT = 4;
    localparam int unsigned Y_SIGN_BIT = 5;

    localparam logic [7:0] CFG_SPEED    = 8'd0;
    localparam logic [7:0] CFG_DEADZONE = 8'd1;
    localparam logic [7:0] CFG_DZ_EN    = 8'd2;
    localparam logic [7:0] CFG_TIMEOUT  = 8'd3;

    localparam logic [3:0] SPEED_RESET    = 4'd3;
    localparam logic [3:0] DEADZONE_RESET = 4'd1;
    localparam logic       DZ_EN_RESET    = 1'b0;
    localparam logic [7:0] TIMEOUT_RESET  = 8'd30;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(32767);
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -WIDE_W'(32768);

    typedef struct packed {
        logic [3:0] speed_multiplier;
        logic [3:0] deadzone;
        logic       deadzone_enable;
        logic [7:0] idle_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic        operation;
        logic [7:0]  rx_byte;
        logic        frame_error;
        logic [31:0] now_ms;
    } item_t;

    function automatic logic signed [SUM_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[SUM_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[SUM_W-1:0];
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/pmd_cfg.sv */
`timescale 1ns / 1ps

module pmd_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output pmd_pkg::cfg_t cfg
);

    pmd_pkg::cfg_t cfg_reg;
    pmd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pmd_pkg::CFG_SPEED:    cfg_next.speed_multiplier = cfg_data[3:0];
                pmd_pkg::CFG_DEADZONE: cfg_next.deadzone         = cfg_data[3:0];
                pmd_pkg::CFG_DZ_EN:    cfg_next.deadzone_enable  = cfg_data[0];
                pmd_pkg::CFG_TIMEOUT:  cfg_next.idle_timeout_ms  = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_multiplier <= pmd_pkg::SPEED_RESET;
            cfg_reg.deadzone         <= pmd_pkg::DEADZONE_RESET;
            cfg_reg.deadzone_enable  <= pmd_pkg::DZ_EN_RESET;
            cfg_reg.idle_timeout_ms  <= pmd_pkg::TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/pmd_track.sv */
`timescale 1ns / 1ps

module pmd_track (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               take,
    input  pmd_pkg::item_t                     item,
    input  pmd_pkg::cfg_t                      cfg,
    output logic signed [pmd_pkg::SUM_W-1:0]   sum_x,
    output logic signed [pmd_pkg::SUM_W-1:0]   sum_y,
    output logic [2:0]                         buttons
);

    logic [7:0]  header_reg, header_next;
    logic [7:0]  x_byte_reg, x_byte_next;
    logic [1:0]  held_reg, held_next;
    logic [31:0] last_good_reg, last_good_next;
    logic signed [pmd_pkg::SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [pmd_pkg::SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [2:0]  buttons_reg, buttons_next;

    logic [31:0] age;
    logic        stale;
    logic [1:0]  held_eff;
    logic signed [8:0] dx, dy;
    logic signed [pmd_pkg::WIDE_W-1:0] wide_x, wide_y;

    assign sum_x   = sum_x_reg;
    assign sum_y   = sum_y_reg;
    assign buttons = buttons_reg;

    assign age      = item.now_ms - last_good_reg;
    assign stale    = (held_reg != 2'd0) && (age > {24'd0, cfg.idle_timeout_ms});
    assign held_eff = stale ? 2'd0 : held_reg;

    assign dx     = $signed({header_reg[pmd_pkg::X_SIGN_BIT], x_byte_reg});
    assign dy     = $signed({header_reg[pmd_pkg::Y_SIGN_BIT], item.rx_byte});
    assign wide_x = pmd_pkg::WIDE_W'(sum_x_reg) + pmd_pkg::WIDE_W'(dx);
    assign wide_y = pmd_pkg::WIDE_W'(sum_y_reg) + pmd_pkg::WIDE_W'(dy);

    always_comb begin
        header_next    = header_reg;
        x_byte_next    = x_byte_reg;
        held_next      = held_reg;
        last_good_next = last_good_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        buttons_next   = buttons_reg;
        if (take) begin
            if (item.operation == pmd_pkg::OP_REPORT) begin
                sum_x_next = '0;
                sum_y_next = '0;
            end else if (item.frame_error) begin
                held_next = 2'd0;
            end else begin
                last_good_next = item.now_ms;
                held_next      = held_eff;
                unique case (held_eff)
                    2'd0: begin
                        if ((item.rx_byte & pmd_pkg::HDR_MASK) == pmd_pkg::HDR_VALUE) begin
                            header_next = item.rx_byte;
                            held_next   = 2'd1;
                        end
                    end
                    2'd1: begin
                        x_byte_next = item.rx_byte;
                        held_next   = 2'd2;
                    end
                    default: begin
                        sum_x_next   = pmd_pkg::sat16(wide_x);
                        sum_y_next   = pmd_pkg::sat16(wide_y);
                        buttons_next = header_reg[2:0];
                        held_next    = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        header_reg <= header_next;
        x_byte_reg <= x_byte_next;
        if (!aresetn) begin
            held_reg      <= 2'd0;
            last_good_reg <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            buttons_reg   <= '0;
        end else begin
            held_reg      <= held_next;
            last_good_reg <= last_good_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            buttons_reg   <= buttons_next;
        end
    end

    a_sums_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (item.operation == pmd_pkg::OP_REPORT) |=> (sum_x_reg == '0) && (sum_y_reg == '0))
        else $error("sums not cleared after report");

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (item.operation == pmd_pkg::OP_BYTE) && item.frame_error |=> held_reg == 2'd0)
        else $error("partial packet kept after bad frame");

    a_held_max: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg != 2'd3)
        else $error("partial packet holds too many bytes");

endmodule

/* hw/rtl/pmd_report.sv */
`timescale 1ns / 1ps

module pmd_report (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  logic signed [pmd_pkg::SUM_W-1:0]   sum_x,
    input  logic signed [pmd_pkg::SUM_W-1:0]   sum_y,
    input  logic [2:0]                         buttons,
    input  pmd_pkg::cfg_t                      cfg,
    output logic                               out_free,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [15:0]                 m_delta_x,
    output logic signed [15:0]                 m_delta_y,
    output logic [2:0]                         m_buttons
);

    logic signed [pmd_pkg::SUM_W-1:0] dz_pos, dz_neg, x_dz, y_dz;
    logic signed [pmd_pkg::WIDE_W-1:0] mult_w, prod_x, prod_y;
    logic signed [15:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [2:0] btn_reg, btn_next;
    logic valid_reg, valid_next;

    assign dz_pos = $signed({12'd0, cfg.deadzone});
    assign dz_neg = -dz_pos;
    assign x_dz = (cfg.deadzone_enable && sum_x <= dz_pos && sum_x >= dz_neg) ? '0 : sum_x;
    assign y_dz = (cfg.deadzone_enable && sum_y <= dz_pos && sum_y >= dz_neg) ? '0 : sum_y;

    assign mult_w = $signed({{(pmd_pkg::WIDE_W-4){1'b0}}, cfg.speed_multiplier});
    assign prod_x = pmd_pkg::WIDE_W'(x_dz) * mult_w;
    assign prod_y = -(pmd_pkg::WIDE_W'(y_dz) * mult_w);

    assign out_free  = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_delta_x = dx_reg;
    assign m_delta_y = dy_reg;
    assign m_buttons = btn_reg;

    always_comb begin
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        btn_next   = btn_reg;
        valid_next = valid_reg;
        if (load) begin
            dx_next    = pmd_pkg::sat16(prod_x);
            dy_next    = pmd_pkg::sat16(prod_y);
            btn_next   = buttons;
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        btn_reg <= btn_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

/* hw/rtl/ps2_mouse_packet_decoder.sv */
`timescale 1ns / 1ps

// channel   direction  ports
// s_        in         s_valid s_ready s_operation s_rx_byte s_frame_error s_now_ms
// m_        out        m_valid m_ready m_delta_x m_delta_y m_buttons
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data
//
// One item per cycle while no report waits; a report reaches m_ through the input register, then the result register.
// Items pass through one input register; packet state updates as each item leaves it.
// A report waits in the input register only while the result register holds an
// item that m_ready has not taken; byte items never wait.
// aresetn is synchronous: registers with a reset value return to it, sums clear.

module ps2_mouse_packet_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_frame_error,
    input  logic [31:0]        s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_delta_x,
    output logic signed [15:0] m_delta_y,
    output logic [2:0]         m_buttons,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    pmd_pkg::cfg_t  cfg;
    pmd_pkg::item_t item_reg, item_next;
    logic           in_valid_reg, in_valid_next;
    logic           advance, is_report, out_free;
    logic signed [pmd_pkg::SUM_W-1:0] sum_x, sum_y;
    logic [2:0]     buttons;

    assign is_report = item_reg.operation == pmd_pkg::OP_REPORT;
    assign advance   = in_valid_reg && (!is_report || out_free);
    assign s_ready   = !in_valid_reg || advance;

    always_comb begin
        item_next     = item_reg;
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            item_next.operation   = s_operation;
            item_next.rx_byte     = s_rx_byte;
            item_next.frame_error = s_frame_error;
            item_next.now_ms      = s_now_ms;
            in_valid_next         = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    pmd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pmd_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .sum_x   (sum_x),
        .sum_y   (sum_y),
        .buttons (buttons)
    );

    pmd_report u_report (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && is_report),
        .sum_x     (sum_x),
        .sum_y     (sum_y),
        .buttons   (buttons),
        .cfg       (cfg),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_delta_x (m_delta_x),
        .m_delta_y (m_delta_y),
        .m_buttons (m_buttons)
    );

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |-> m_valid && !m_ready && is_report)
        else $error("input stage held without a blocked result");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(advance && is_report))
        else $error("result raised without a report");

    a_report_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_report |=> m_valid)
        else $error("report did not reach the result register");

endmodule

/* verif/tb_ps2_mouse_packet_decoder.sv */
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [2:0]         btn;
    } report_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic               s_operation   = pmd_pkg::OP_BYTE;
    logic [7:0]         s_rx_byte     = '0;
    logic               s_frame_error = 1'b0;
    logic [31:0]        s_now_ms      = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic signed [15:0] m_delta_x;
    logic signed [15:0] m_delta_y;
    logic [2:0]         m_buttons;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_index     = '0;
    logic [7:0]         cfg_data      = '0;

    ps2_mouse_packet_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_rx_byte     (s_rx_byte),
        .s_frame_error (s_frame_error),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_delta_x     (m_delta_x),
        .m_delta_y     (m_delta_y),
        .m_buttons     (m_buttons),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 aclk = ~aclk;

    // decoder state as seen from outside
    logic [3:0]         cfg_speed    = pmd_pkg::SPEED_RESET;
    logic [3:0]         cfg_dz       = pmd_pkg::DEADZONE_RESET;
    logic               cfg_dz_en    = pmd_pkg::DZ_EN_RESET;
    logic [7:0]         cfg_timeout  = pmd_pkg::TIMEOUT_RESET;
    logic [7:0]         pkt_hdr      = '0;
    logic [7:0]         pkt_x        = '0;
    logic [1:0]         pkt_count    = '0;
    logic [31:0]        last_good_ms = '0;
    logic signed [15:0] sum_x        = '0;
    logic signed [15:0] sum_y        = '0;
    logic [2:0]         held_btn     = '0;

    pmd_pkg::item_t pending_items[$];
    report_t expected_reports[$];
    pmd_pkg::item_t in_flight;
    logic [31:0] stamp_ms;
    bit      steady       = 1'b0;
    int      mismatches   = 0;
    int      stall_cycles = 0;

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic int apply_dz(input int v);
        int dz;
        dz = int'(cfg_dz);
        if (cfg_dz_en && v <= dz && v >= -dz) return 0;
        return v;
    endfunction

    task automatic decode_item(input pmd_pkg::item_t it);
        report_t r;
        int x;
        int y;
        int m;
        int dx;
        int dy;
        if (it.operation == pmd_pkg::OP_REPORT) begin
            x = apply_dz(int'(sum_x));
            y = apply_dz(int'(sum_y));
            m = int'(cfg_speed);
            r.dx = clamp16(x * m);
            r.dy = clamp16(-(y * m));
            r.btn = held_btn;
            expected_reports.push_back(r);
            sum_x = '0;
            sum_y = '0;
        end else begin
            if (pkt_count != 2'd0 && (it.now_ms - last_good_ms) > {24'b0, cfg_timeout}) begin
                pkt_count = 2'd0;
            end
            if (it.frame_error) begin
                pkt_count = 2'd0;
            end else begin
                last_good_ms = it.now_ms;
                case (pkt_count)
                    2'd0: begin
                        if ((it.rx_byte & pmd_pkg::HDR_MASK) == pmd_pkg::HDR_VALUE) begin
                            pkt_hdr = it.rx_byte;
                            pkt_count = 2'd1;
                        end
                    end
                    2'd1: begin
                        pkt_x = it.rx_byte;
                        pkt_count = 2'd2;
                    end
                    default: begin
                        dx = pkt_hdr[pmd_pkg::X_SIGN_BIT] ? int'(pkt_x) - 256 : int'(pkt_x);
                        dy = pkt_hdr[pmd_pkg::Y_SIGN_BIT] ? int'(it.rx_byte) - 256
                                                          : int'(it.rx_byte);
                        sum_x = clamp16(int'(sum_x) + dx);
                        sum_y = clamp16(int'(sum_y) + dy);
                        held_btn = pkt_hdr[2:0];
                        pkt_count = 2'd0;
                    end
                endcase
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            pmd_pkg::CFG_SPEED:    cfg_speed   = data[3:0];
            pmd_pkg::CFG_DEADZONE: cfg_dz      = data[3:0];
            pmd_pkg::CFG_DZ_EN:    cfg_dz_en   = data[0];
            pmd_pkg::CFG_TIMEOUT:  cfg_timeout = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || s_valid || expected_reports.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic int unsigned pick_gap(input bit tight);
        int unsigned t;
        t = cfg_timeout;
        if (tight) return $urandom_range(t);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return $urandom_range(t);
            6: return t;
            7: return t + 1;
            8: return $urandom_range(600);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_delta();
        if ($urandom_range(2) == 0) return int'($urandom_range(16)) - 8;
        return int'($urandom_range(511)) - 256;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic ferr, input int unsigned gap);
        stamp_ms = stamp_ms + gap;
        pending_items.push_back(pmd_pkg::item_t'{pmd_pkg::OP_BYTE, b, ferr, stamp_ms});
    endtask

    task automatic add_report();
        pending_items.push_back(pmd_pkg::item_t'{pmd_pkg::OP_REPORT, 8'($urandom_range(255)),
                                                 1'($urandom_range(1)), 32'($urandom)});
    endtask

    task automatic add_packet(input int dx, input int dy, input logic [2:0] btn,
                              input bit loose);
        logic [7:0] hdr;
        hdr = {2'b00, dy < 0, dx < 0, 1'b1, btn};
        add_byte(hdr, 1'b0, pick_gap(!loose));
        add_byte(dx[7:0], 1'b0, pick_gap(!(loose && $urandom_range(9) == 0)));
        add_byte(dy[7:0], 1'b0, pick_gap(!(loose && $urandom_range(9) == 0)));
    endtask

    // push > 0 drives sums to +X/-Y saturation, push < 0 the opposite
    task automatic gen_traffic(input int n, input int report_pct, input int push);
        int done;
        logic [7:0] b;
        done = 0;
        while (done < n) begin
            if (push != 0) begin
                add_packet(push > 0 ? 255 : -256, push > 0 ? -256 : 255,
                           3'($urandom_range(7)), 1'b0);
                done += 3;
            end else if ($urandom_range(99) < report_pct) begin
                add_report();
                done += 1;
            end else if ($urandom_range(99) < 78) begin
                add_packet(pick_delta(), pick_delta(), 3'($urandom_range(7)), 1'b1);
                done += 3;
            end else begin
                case ($urandom_range(4))
                    0: add_byte(8'($urandom_range(255)), 1'b0, pick_gap(1'b0));
                    1: add_byte(8'($urandom_range(255)), 1'b1, pick_gap(1'b0));
                    2: begin
                        b = 8'($urandom_range(255)) | pmd_pkg::HDR_VALUE;
                        b[7:6] = 2'($urandom_range(1, 3));
                        add_byte(b, 1'b0, pick_gap(1'b0));
                    end
                    3: begin
                        // truncated packet: the next header lands as its third byte
                        add_byte({4'($urandom_range(3)), 1'b1, 3'($urandom_range(7))}, 1'b0,
                                 pick_gap(1'b1));
                        add_byte(8'($urandom_range(255)), 1'b0, pick_gap(1'b1));
                    end
                    default: begin
                        add_byte({4'($urandom_range(3)), 1'b1, 3'($urandom_range(7))}, 1'b0,
                                 pick_gap(1'b1));
                        add_byte(8'($urandom_range(255)), 1'b0, pick_gap(1'b1));
                        add_byte(8'($urandom_range(255)), 1'b1, pick_gap(1'b1));
                    end
                endcase
            end
        end
    endtask

    always @(posedge aclk) begin : sender
        if (aresetn) begin
            if (s_valid && s_ready) decode_item(in_flight);
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
                    in_flight = pending_items.pop_front();
                    s_valid       <= 1'b1;
                    s_operation   <= in_flight.operation;
                    s_rx_byte     <= in_flight.rx_byte;
                    s_frame_error <= in_flight.frame_error;
                    s_now_ms      <= in_flight.now_ms;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : receiver
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                note_mismatch($sformatf("report with none pending: dx %0d dy %0d buttons %0d",
                                        m_delta_x, m_delta_y, m_buttons));
            end else begin
                want = expected_reports.pop_front();
                if (m_delta_x !== want.dx)
                    note_mismatch($sformatf("delta_x %0d, want %0d", m_delta_x, want.dx));
                if (m_delta_y !== want.dy)
                    note_mismatch($sformatf("delta_y %0d, want %0d", m_delta_y, want.dy));
                if (m_buttons !== want.btn)
                    note_mismatch($sformatf("buttons %0d, want %0d", m_buttons, want.btn));
            end
        end
        m_ready <= steady || ($urandom_range(99) >= 17);
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        stamp_ms = $urandom;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_report();
        pending_items.push_back(pmd_pkg::item_t'{pmd_pkg::OP_REPORT, 8'hFF, 1'b1,
                                                 32'hFFFF_FFFF});
        add_packet(255, -256, 3'b111, 1'b0);
        add_report();
        add_packet(-256, 255, 3'b000, 1'b0);
        add_report();
        add_byte(8'h88, 1'b0, 1);
        add_byte(8'h48, 1'b0, 1);
        add_byte(8'h00, 1'b0, 1);
        add_byte(8'h08, 1'b1, 1);
        // drop a partial packet on a bad frame
        add_byte(8'h09, 1'b0, 1);
        add_byte(8'h10, 1'b0, 1);
        add_byte(8'h20, 1'b1, 1);
        add_byte(8'h05, 1'b0, 1);
        // drop on timeout, then complete right at the limit across the time wrap
        add_byte(8'h0A, 1'b0, 1);
        add_byte(8'h07, 1'b0, 31);
        stamp_ms = 32'hFFFF_FFF8;
        add_byte(8'h0C, 1'b0, 2);
        add_byte(8'h02, 1'b0, 30);
        add_byte(8'hFE, 1'b0, 30);
        add_report();
        settle();

        write_reg(pmd_pkg::CFG_SPEED, 8'd15);
        write_reg(pmd_pkg::CFG_DEADZONE, 8'd15);
        write_reg(pmd_pkg::CFG_DZ_EN, 8'd1);
        write_reg(pmd_pkg::CFG_TIMEOUT, 8'd0);
        @(negedge aclk);
        gen_traffic(60, 25, 0);
        settle();

        write_reg(pmd_pkg::CFG_SPEED, 8'd0);
        write_reg(pmd_pkg::CFG_DEADZONE, 8'd0);
        write_reg(pmd_pkg::CFG_TIMEOUT, 8'd255);
        @(negedge aclk);
        gen_traffic(50, 25, 0);
        settle();

        write_reg(pmd_pkg::CFG_SPEED, 8'd1);
        write_reg(pmd_pkg::CFG_DEADZONE, 8'd7);
        write_reg(pmd_pkg::CFG_DZ_EN, 8'd0);
        @(negedge aclk);
        gen_traffic(400, 0, 1);
        add_report();
        gen_traffic(400, 0, -1);
        add_report();
        settle();

        steady = 1'b1;
        write_reg(pmd_pkg::CFG_SPEED, {4'($urandom_range(15)), 4'($urandom_range(15))});
        write_reg(pmd_pkg::CFG_DEADZONE, {4'($urandom_range(15)), 4'($urandom_range(15))});
        write_reg(pmd_pkg::CFG_DZ_EN, {7'($urandom), 1'($urandom_range(1))});
        write_reg(pmd_pkg::CFG_TIMEOUT, 8'($urandom_range(255)));
        write_reg(8'($urandom_range(4, 255)), 8'($urandom));
        @(negedge aclk);
        gen_traffic(120, 20, 0);
        settle();
        steady = 1'b0;

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
